// ----- src/vrrbt_pkg.sv -----
// ----------------------------------------------------------------------------
// vrrbt_pkg
// Shared codes and types for the VIP round-robin backend table.
// ----------------------------------------------------------------------------
`default_nettype none

package vrrbt_pkg;

    // Default table geometry
    localparam int ROUTE_ENTRIES_DEF      = 256;
    localparam int BACKENDS_PER_ROUTE_DEF = 32;

    // Request mode codes
    localparam logic MODE_SELECT = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // Scan unit response toward the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

endpackage

`default_nettype wire

// ----- src/vrrbt_vip_scan.sv -----
// ----------------------------------------------------------------------------
// vrrbt_vip_scan
// VIP table memory with a linear search unit: one entry read per cycle,
// compare on the registered read data, stop on the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module vrrbt_vip_scan #(
    parameter int ROUTE_ENTRIES = vrrbt_pkg::ROUTE_ENTRIES_DEF,
    parameter int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
    parameter int RC_W          = $clog2(ROUTE_ENTRIES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // search request
    input  wire logic                 scan_start,
    input  wire logic [31:0]          scan_vip,
    input  wire logic [RC_W-1:0]      scan_count,
    output vrrbt_pkg::scan_rsp_t      scan_rsp,
    output logic      [IDX_W-1:0]     scan_idx,
    // table write port
    input  wire logic                 vip_we,
    input  wire logic [IDX_W-1:0]     vip_widx,
    input  wire logic [31:0]          vip_wdata
);
    import vrrbt_pkg::*;

    logic [31:0]     vip_mem [ROUTE_ENTRIES];
    logic [31:0]     vip_rdata_reg;

    logic            busy_reg,      busy_next;
    logic [RC_W-1:0] addr_reg,      addr_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg,  cmp_idx_next;
    logic            rd_en;
    logic            hit;

    // Compare the entry read in the previous cycle
    assign hit = cmp_valid_reg && (vip_rdata_reg == scan_vip);

    // Step the search: match ends it, otherwise read the next entry or give up
    always_comb
    begin
        busy_next      = busy_reg;
        addr_next      = addr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        rd_en          = 1'b0;
        scan_rsp.done  = 1'b0;
        scan_rsp.hit   = 1'b0;
        if (scan_start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                scan_rsp.done = 1'b1;
                scan_rsp.hit  = 1'b1;
                busy_next     = 1'b0;
            end
            else if (addr_reg < scan_count)
            begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = addr_reg[IDX_W-1:0];
                addr_next      = addr_reg + RC_W'(1);
            end
            else
            begin
                scan_rsp.done = 1'b1;
                busy_next     = 1'b0;
            end
        end
    end

    assign scan_idx = cmp_idx_reg;

    // Hold search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            addr_reg      <= addr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
        end
    end

    // VIP table memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (vip_we)
        begin
            vip_mem[vip_widx] <= vip_wdata;
        end
        if (rd_en)
        begin
            vip_rdata_reg <= vip_mem[addr_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- src/vrrbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// vrrbt_ctrl
// Request sequencer with the per-entry count/pointer memory and the backend
// store. Runs update appends and round-robin selects as read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module vrrbt_ctrl #(
    parameter int ROUTE_ENTRIES      = vrrbt_pkg::ROUTE_ENTRIES_DEF,
    parameter int BACKENDS_PER_ROUTE = vrrbt_pkg::BACKENDS_PER_ROUTE_DEF,
    parameter int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
    parameter int RC_W  = $clog2(ROUTE_ENTRIES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request beat
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [31:0]          vip,
    input  wire logic [31:0]          pod_ip,
    input  wire logic                 pod_valid,
    input  wire logic                 update_last,
    // scan unit
    output logic                      scan_start,
    output logic      [31:0]          scan_vip,
    output logic      [RC_W-1:0]      scan_count,
    input  wire vrrbt_pkg::scan_rsp_t scan_rsp,
    input  wire logic [IDX_W-1:0]     scan_idx,
    output logic                      vip_we,
    output logic      [IDX_W-1:0]     vip_widx,
    output logic      [31:0]          vip_wdata,
    // result toward the output register
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic      [1:0]           res_status,
    output logic      [31:0]          res_ip
);
    import vrrbt_pkg::*;

    localparam int CNT_W    = $clog2(BACKENDS_PER_ROUTE + 1);
    localparam int PTR_W    = (BACKENDS_PER_ROUTE > 1) ? $clog2(BACKENDS_PER_ROUTE) : 1;
    localparam int META_W   = CNT_W + PTR_W;
    localparam int BE_DEPTH = ROUTE_ENTRIES * BACKENDS_PER_ROUTE;
    localparam int BE_AW    = (BE_DEPTH > 1) ? $clog2(BE_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_APPEND   = 6'b000100,
        S_SEL_META = 6'b001000,
        S_SEL_BE   = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [31:0]      vip_reg, vip_next;
    logic [31:0]      pod_ip_reg, pod_ip_next;
    logic             pod_valid_reg, pod_valid_next;
    logic             last_reg, last_next;
    logic [RC_W-1:0]  route_count_reg, route_count_next;
    logic             update_open_reg, update_open_next;
    logic [IDX_W-1:0] update_entry_reg, update_entry_next;
    logic             update_failed_reg, update_failed_next;
    logic [IDX_W-1:0] sel_idx_reg, sel_idx_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [31:0]      res_ip_reg, res_ip_next;

    // memories
    logic [META_W-1:0] meta_mem [ROUTE_ENTRIES];
    logic [31:0]       be_mem [BE_DEPTH];
    logic [META_W-1:0] meta_rdata_reg;
    logic [31:0]       be_rdata_reg;

    logic              meta_re, meta_we;
    logic [IDX_W-1:0]  meta_raddr, meta_waddr;
    logic [META_W-1:0] meta_wdata;
    logic              be_re, be_we;
    logic [BE_AW-1:0]  be_raddr, be_waddr;

    logic [CNT_W-1:0]  meta_cnt;
    logic [PTR_W-1:0]  meta_ptr;
    logic [PTR_W-1:0]  sel_ptr;
    logic [CNT_W-1:0]  ptr_inc;
    logic [PTR_W-1:0]  ptr_adv;
    logic              table_full;
    logic [IDX_W-1:0]  new_idx;

    function automatic logic [BE_AW-1:0] be_addr(input logic [IDX_W-1:0] idx,
                                                  input logic [PTR_W-1:0] off);
        logic [BE_AW-1:0] base;
        base = BE_AW'(idx) * BE_AW'(BACKENDS_PER_ROUTE);
        return base + BE_AW'(off);
    endfunction

    // Split the entry word and work out the round-robin step
    assign meta_cnt   = meta_rdata_reg[META_W-1:PTR_W];
    assign meta_ptr   = meta_rdata_reg[PTR_W-1:0];
    assign sel_ptr    = (CNT_W'(meta_ptr) >= meta_cnt) ? '0 : meta_ptr;
    assign ptr_inc    = CNT_W'(sel_ptr) + CNT_W'(1);
    assign ptr_adv    = (ptr_inc >= meta_cnt) ? '0 : ptr_inc[PTR_W-1:0];
    assign table_full = (route_count_reg == RC_W'(ROUTE_ENTRIES));
    assign new_idx    = scan_rsp.hit ? scan_idx : route_count_reg[IDX_W-1:0];

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESULT);
    assign res_status = res_status_reg;
    assign res_ip     = res_ip_reg;
    assign scan_vip   = vip_reg;
    assign scan_count = route_count_reg;
    assign vip_widx   = route_count_reg[IDX_W-1:0];
    assign vip_wdata  = vip_reg;

    // Sequence one request beat
    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        vip_next           = vip_reg;
        pod_ip_next        = pod_ip_reg;
        pod_valid_next     = pod_valid_reg;
        last_next          = last_reg;
        route_count_next   = route_count_reg;
        update_open_next   = update_open_reg;
        update_entry_next  = update_entry_reg;
        update_failed_next = update_failed_reg;
        sel_idx_next       = sel_idx_reg;
        res_status_next    = res_status_reg;
        res_ip_next        = res_ip_reg;
        scan_start         = 1'b0;
        vip_we             = 1'b0;
        meta_re            = 1'b0;
        meta_raddr         = update_entry_reg;
        meta_we            = 1'b0;
        meta_waddr         = update_entry_reg;
        meta_wdata         = meta_rdata_reg;
        be_re              = 1'b0;
        be_raddr           = be_addr(sel_idx_reg, sel_ptr);
        be_we              = 1'b0;
        be_waddr           = be_addr(update_entry_reg, meta_cnt[PTR_W-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    vip_next        = vip;
                    pod_ip_next     = pod_ip;
                    pod_valid_next  = pod_valid;
                    last_next       = update_last;
                    res_ip_next     = '0;
                    if (mode == MODE_UPDATE && update_open_reg)
                    begin
                        if (update_failed_reg)
                        begin
                            // refused run: answer full, close on its last beat
                            res_status_next = ST_FULL;
                            if (update_last)
                            begin
                                update_open_next   = 1'b0;
                                update_failed_next = 1'b0;
                            end
                            state_next = S_RESULT;
                        end
                        else if (!pod_valid)
                        begin
                            res_status_next = ST_OK;
                            if (update_last)
                            begin
                                update_open_next = 1'b0;
                            end
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            meta_re    = 1'b1;
                            state_next = S_APPEND;
                        end
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_APPEND:
            begin
                // append if room is left, drop otherwise
                if (meta_cnt < CNT_W'(BACKENDS_PER_ROUTE))
                begin
                    be_we      = 1'b1;
                    meta_we    = 1'b1;
                    meta_wdata = {meta_cnt + CNT_W'(1), meta_ptr};
                end
                res_status_next = ST_OK;
                if (last_reg)
                begin
                    update_open_next = 1'b0;
                end
                state_next = S_RESULT;
            end

            S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    if (mode_reg == MODE_SELECT)
                    begin
                        if (!scan_rsp.hit)
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            meta_re      = 1'b1;
                            meta_raddr   = scan_idx;
                            sel_idx_next = scan_idx;
                            state_next   = S_SEL_META;
                        end
                    end
                    else
                    begin
                        if (!scan_rsp.hit && table_full)
                        begin
                            // open a refused run unless it ends here
                            update_open_next   = !last_reg;
                            update_failed_next = !last_reg;
                            res_status_next    = ST_FULL;
                        end
                        else
                        begin
                            // find or create the entry, reset its list
                            if (!scan_rsp.hit)
                            begin
                                route_count_next = route_count_reg + RC_W'(1);
                                vip_we           = 1'b1;
                            end
                            meta_we    = 1'b1;
                            meta_waddr = new_idx;
                            meta_wdata = {CNT_W'(pod_valid_reg), PTR_W'(0)};
                            be_we      = pod_valid_reg;
                            be_waddr   = be_addr(new_idx, '0);
                            update_entry_next  = new_idx;
                            update_open_next   = !last_reg;
                            update_failed_next = 1'b0;
                            res_status_next    = ST_OK;
                        end
                        state_next = S_RESULT;
                    end
                end
            end

            S_SEL_META:
            begin
                if (meta_cnt == '0)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_RESULT;
                end
                else
                begin
                    // read the backend at the pointer, write back the advanced pointer
                    be_re      = 1'b1;
                    meta_we    = 1'b1;
                    meta_waddr = sel_idx_reg;
                    meta_wdata = {meta_cnt, ptr_adv};
                    state_next = S_SEL_BE;
                end
            end

            S_SEL_BE:
            begin
                res_status_next = ST_OK;
                res_ip_next     = be_rdata_reg;
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            route_count_reg   <= '0;
            update_open_reg   <= 1'b0;
            update_entry_reg  <= '0;
            update_failed_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            route_count_reg   <= route_count_next;
            update_open_reg   <= update_open_next;
            update_entry_reg  <= update_entry_next;
            update_failed_reg <= update_failed_next;
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        vip_reg        <= vip_next;
        pod_ip_reg     <= pod_ip_next;
        pod_valid_reg  <= pod_valid_next;
        last_reg       <= last_next;
        sel_idx_reg    <= sel_idx_next;
        res_status_reg <= res_status_next;
        res_ip_reg     <= res_ip_next;
    end

    // Count/pointer memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re)
        begin
            meta_rdata_reg <= meta_mem[meta_raddr];
        end
    end

    // Backend store
    always_ff @(posedge clk)
    begin
        if (be_we)
        begin
            be_mem[be_waddr] <= pod_ip_reg;
        end
        if (be_re)
        begin
            be_rdata_reg <= be_mem[be_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/vip_round_robin_backend_table_top.sv -----
// ----------------------------------------------------------------------------
// vip_round_robin_backend_table_top
// VIP table with packed backend lists and a round-robin pointer per VIP.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_ready   mode, vip, pod_ip, pod_valid,
//                                              update_last
//   result    out        out_valid / out_ready status, backend_ip
//
// One request beat is taken at a time. A later element of an open update run
// skips the search and, when it appends, reads the entry word first. A select
// or the first element of a run searches the VIP table memory one entry per
// cycle, up to the matching entry or, for an absent VIP, through every entry
// in use; a select that hits reads the entry word and, unless empty, a backend.
// Reset clears the sequencer and the entry count; the table memories need no
// clearing pass. A stalled result sits in the output register while the next
// request is accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module vip_round_robin_backend_table_top #(
    parameter int ROUTE_ENTRIES      = vrrbt_pkg::ROUTE_ENTRIES_DEF,
    parameter int BACKENDS_PER_ROUTE = vrrbt_pkg::BACKENDS_PER_ROUTE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [31:0] vip,
    input  wire logic [31:0] pod_ip,
    input  wire logic        pod_valid,
    input  wire logic        update_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      backend_ip
);
    import vrrbt_pkg::*;

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int RC_W  = $clog2(ROUTE_ENTRIES + 1);

    logic             scan_start;
    logic [31:0]      scan_vip;
    logic [RC_W-1:0]  scan_count;
    scan_rsp_t        scan_rsp;
    logic [IDX_W-1:0] scan_idx;
    logic             vip_we;
    logic [IDX_W-1:0] vip_widx;
    logic [31:0]      vip_wdata;
    logic             res_valid;
    logic             res_ready;
    logic [1:0]       res_status;
    logic [31:0]      res_ip;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg;
    logic [31:0]      backend_ip_reg;

    vrrbt_vip_scan #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IDX_W         (IDX_W),
        .RC_W          (RC_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_start (scan_start),
        .scan_vip   (scan_vip),
        .scan_count (scan_count),
        .scan_rsp   (scan_rsp),
        .scan_idx   (scan_idx),
        .vip_we     (vip_we),
        .vip_widx   (vip_widx),
        .vip_wdata  (vip_wdata)
    );

    vrrbt_ctrl #(
        .ROUTE_ENTRIES      (ROUTE_ENTRIES),
        .BACKENDS_PER_ROUTE (BACKENDS_PER_ROUTE),
        .IDX_W              (IDX_W),
        .RC_W               (RC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .vip         (vip),
        .pod_ip      (pod_ip),
        .pod_valid   (pod_valid),
        .update_last (update_last),
        .scan_start  (scan_start),
        .scan_vip    (scan_vip),
        .scan_count  (scan_count),
        .scan_rsp    (scan_rsp),
        .scan_idx    (scan_idx),
        .vip_we      (vip_we),
        .vip_widx    (vip_widx),
        .vip_wdata   (vip_wdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_status  (res_status),
        .res_ip      (res_ip)
    );

    // Load a result when the output register is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg     <= res_status;
            backend_ip_reg <= res_ip;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign backend_ip = backend_ip_reg;

endmodule

`default_nettype wire
